// ===== rtl/line_integral_convolution_assert.svh =====
// Assertion macros shared by the line integral convolution RTL
`ifndef LINE_INTEGRAL_CONVOLUTION_ASSERT_SVH
`define LINE_INTEGRAL_CONVOLUTION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define LIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lic_pkg.sv =====
// Package: sizes, fixed-point constants and state codes for the LIC block
`timescale 1ns / 1ps
package lic_pkg;

  localparam int IMG_WIDTH   = 512;
  localparam int IMG_HEIGHT  = 512;
  localparam int HALF_LENGTH = 64;

  localparam int PIX_W   = 9;
  localparam int GRAY_W  = 8;
  localparam int TDATA_W = 32;

  localparam int STORE_DEPTH = IMG_WIDTH * IMG_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Fixed point: signed, 20 fraction bits, 11 integer bits plus sign
  localparam int FRAC_BITS = 20;
  localparam int POS_W     = 32;
  localparam int INT_W     = POS_W - 1 - FRAC_BITS;
  localparam int DSQ_W     = 11;
  localparam int PROD_W    = POS_W + DSQ_W;
  localparam int DS_Q      = 683;
  localparam int FIELD_CENTER = 256;

  // Sample count and averaging
  localparam int NPTS    = 2 * HALF_LENGTH + 1;
  localparam int SMP_W   = $clog2(NPTS);
  localparam int MAX_SUM = NPTS * 255;
  localparam int SUM_W   = $clog2(MAX_SUM + 1);

  // Mean by reciprocal multiplication: exact for every sum below NPTS * 256
  localparam int DIV_SHIFT = 2 * SMP_W + GRAY_W;
  localparam int DIV_MUL   = (2 ** DIV_SHIFT + NPTS - 1) / NPTS;
  localparam int MUL_W     = $clog2(DIV_MUL + 1);
  localparam int QPROD_W   = SUM_W + MUL_W;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TRACE = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

// ===== rtl/lic_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module lic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/line_integral_convolution.sv =====
// Top level: frame store, streamline tracer and averaging divider
//
// Line integral convolution with a box kernel over the rotational field
// v = (-(y-256), x-256). A load item (in_tuser = 0) writes one gray pixel
// into the 512x512 frame store, leaving the block idle; loads outside the image
// are dropped. A compute item (in_tuser = 1) traces HALF_LENGTH forward and
// HALF_LENGTH backward Euler steps of size 1/1536 from the named pixel, sums
// the 2*HALF_LENGTH+1 stored samples (zero outside the image) and returns the
// truncated mean. A compute item occupies the block while it makes one
// frame store read per sample on the single-port store, a drain step, a
// reciprocal multiplication for the mean and a hand-off into the output
// register; the hand-off waits as long as an earlier result is still held
// there. The store is not cleared at reset; pixels must be loaded before
// they are sampled.
`timescale 1ns / 1ps
module line_integral_convolution (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lic_pkg::TDATA_W-1:0] in_tdata,  // pix_x, pix_y, gray_in, zero pad
  input  logic                        in_tuser,  // cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lic_pkg::TDATA_W-1:0] out_tdata  // out_x, out_y, gray_out, zero pad
);
  import lic_pkg::*;

  `include "line_integral_convolution_assert.svh"

  state_t state_r, state_nxt;

  logic [PIX_W-1:0]  pix_x, pix_y;
  logic [GRAY_W-1:0] gray_in;
  logic              in_acc;

  logic signed [POS_W-1:0] pos_x_r, pos_y_r, start_x_r, start_y_r;
  logic signed [POS_W-1:0] base_x, base_y, vx, vy, dx, dy, step_x, step_y;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic [SMP_W-1:0]  smp_r;
  logic              bwd;
  logic [PIX_W-1:0]  keep_x_r, keep_y_r;

  logic [INT_W-1:0]  ix, iy;
  logic              in_img;
  logic              rd_valid_r, rd_in_r;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [GRAY_W-1:0] ram_rdata;

  logic [SUM_W-1:0]   sum_r, sum_nxt, rem_r;
  logic [QPROD_W-1:0] quo_prod;
  logic [GRAY_W-1:0]  quo_r;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_x_r, out_y_r;
  logic [GRAY_W-1:0] out_gray_r;
  logic              out_load;

  localparam logic signed [POS_W-1:0] CENTER_Q = POS_W'(FIELD_CENTER) <<< FRAC_BITS;

  // Unpack the input item
  assign pix_x   = in_tdata[PIX_W-1:0];
  assign pix_y   = in_tdata[2*PIX_W-1:PIX_W];
  assign gray_in = in_tdata[2*PIX_W+GRAY_W-1:2*PIX_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Euler step: forward until the first half is done, then back from the start
  assign bwd    = (smp_r >= SMP_W'(HALF_LENGTH));
  assign base_x = (smp_r == SMP_W'(HALF_LENGTH)) ? start_x_r : pos_x_r;
  assign base_y = (smp_r == SMP_W'(HALF_LENGTH)) ? start_y_r : pos_y_r;
  assign vx     = CENTER_Q - base_y;
  assign vy     = base_x - CENTER_Q;
  assign prod_x = PROD_W'(vx) * PROD_W'(DS_Q);
  assign prod_y = PROD_W'(vy) * PROD_W'(DS_Q);
  assign dx     = POS_W'(prod_x >>> FRAC_BITS);
  assign dy     = POS_W'(prod_y >>> FRAC_BITS);
  assign step_x = bwd ? base_x - dx : base_x + dx;
  assign step_y = bwd ? base_y - dy : base_y + dy;

  // Sample position to pixel address
  assign ix     = pos_x_r[POS_W-2:FRAC_BITS];
  assign iy     = pos_y_r[POS_W-2:FRAC_BITS];
  assign in_img = !pos_x_r[POS_W-1] && !pos_y_r[POS_W-1] &&
                  (ix < INT_W'(IMG_WIDTH)) && (iy < INT_W'(IMG_HEIGHT));

  // The store port serves loads when idle and samples while tracing
  always_comb begin
    if (state_r == S_IDLE) begin
      ram_addr = ADDR_W'(pix_y) * ADDR_W'(IMG_WIDTH) + ADDR_W'(pix_x);
      ram_we   = in_acc && (in_tuser == CMD_LOAD) &&
                 (INT_W'(pix_x) < INT_W'(IMG_WIDTH)) &&
                 (INT_W'(pix_y) < INT_W'(IMG_HEIGHT));
    end else begin
      ram_addr = ADDR_W'(iy) * ADDR_W'(IMG_WIDTH) + ADDR_W'(ix);
      ram_we   = 1'b0;
    end
  end

  lic_ram #(
    .WIDTH(GRAY_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(gray_in),
    .rdata(ram_rdata)
  );

  // Accumulate returning samples
  assign sum_nxt = (rd_valid_r && rd_in_r) ? sum_r + SUM_W'(ram_rdata) : sum_r;

  // Divide by the point count: multiply by the scaled reciprocal, keep the top bits
  assign quo_prod = QPROD_W'(rem_r) * QPROD_W'(DIV_MUL);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == CMD_COMPUTE)) begin
          state_nxt = S_TRACE;
        end
      end
      S_TRACE: begin
        if (smp_r == SMP_W'(NPTS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_DIV;
      S_DIV:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= (state_r == S_TRACE);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_in_r <= in_img;
    sum_r   <= in_acc ? '0 : sum_nxt;
    if (in_acc) begin
      start_x_r <= $signed({{(POS_W-FRAC_BITS-PIX_W){1'b0}}, pix_x, {FRAC_BITS{1'b0}}});
      start_y_r <= $signed({{(POS_W-FRAC_BITS-PIX_W){1'b0}}, pix_y, {FRAC_BITS{1'b0}}});
      pos_x_r   <= $signed({{(POS_W-FRAC_BITS-PIX_W){1'b0}}, pix_x, {FRAC_BITS{1'b0}}});
      pos_y_r   <= $signed({{(POS_W-FRAC_BITS-PIX_W){1'b0}}, pix_y, {FRAC_BITS{1'b0}}});
      keep_x_r  <= pix_x;
      keep_y_r  <= pix_y;
      smp_r     <= '0;
    end
    if (state_r == S_TRACE) begin
      pos_x_r <= step_x;
      pos_y_r <= step_y;
      smp_r   <= smp_r + SMP_W'(1);
    end
    // Hold the final sum, including the last sample
    if (state_r == S_DRAIN) begin
      rem_r <= sum_nxt;
    end
    if (state_r == S_DIV) begin
      quo_r <= quo_prod[DIV_SHIFT +: GRAY_W];
    end
    if (out_load) begin
      out_x_r    <= keep_x_r;
      out_y_r    <= keep_y_r;
      out_gray_r <= quo_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-2*PIX_W-GRAY_W){1'b0}}, out_gray_r, out_y_r, out_x_r};

  `LIC_ASSERT_NOW(a_we_idle, ram_we, state_r == S_IDLE, "store write outside idle")
  `LIC_ASSERT_NOW(a_rd_trace, rd_valid_r, $past(state_r) == S_TRACE, "sample without trace")
  `LIC_ASSERT_NOW(a_sum_max, state_r == S_DIV, rem_r <= SUM_W'(MAX_SUM), "sum out of range")
  `LIC_ASSERT_NEXT(a_div_one, state_r == S_DIV, state_r == S_DONE, "mean not ready in time")

endmodule

// ===== dv/line_integral_convolution_tb.sv =====
// Testbench for the line integral convolution block: scoreboard and stimulus
`timescale 1ns / 1ps
module line_integral_convolution_tb;
  import lic_pkg::*;

  localparam int  LIMIT_CYCLES = 200000;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  DRAIN_WAIT   = 2 * HALF_LENGTH + 40;
  localparam int  RAND_ITEMS   = 150;
  localparam int  CALM_ITEMS   = 40;
  localparam int  BLOCK_LO     = 250;
  localparam int  BLOCK_HI     = 261;
  localparam int  ZONE_LO      = 248;
  localparam int  ZONE_HI      = 263;

  typedef struct packed {
    logic [PIX_W-1:0]  x;
    logic [PIX_W-1:0]  y;
    logic [GRAY_W-1:0] gray;
  } lic_pixel_t;

  // Mirror of the frame store and the streamline average it yields
  class lic_scoreboard;
    logic [GRAY_W-1:0] frame [STORE_DEPTH];
    bit                written [STORE_DEPTH];
    lic_pixel_t        awaited[$];
    int                errors;
    int                loads;
    int                computes;
    int                checked;

    function longint step_of(longint v);
      longint p;
      p = v * DS_Q;
      if (p >= 0) return p >>> FRAC_BITS;
      return -((-p + (64'd1 << FRAC_BITS) - 1) >>> FRAC_BITS);
    endfunction

    function int gray_at(longint x, longint y);
      longint ix, iy;
      if (x < 0 || y < 0) return 0;
      ix = x >>> FRAC_BITS;
      iy = y >>> FRAC_BITS;
      if (ix >= IMG_WIDTH || iy >= IMG_HEIGHT) return 0;
      return frame[iy * IMG_WIDTH + ix];
    endfunction

    function int half_sum(longint x0, longint y0, bit backward);
      longint c, x, y, dx, dy;
      int     total;
      c = longint'(FIELD_CENTER) << FRAC_BITS;
      x = x0;
      y = y0;
      total = 0;
      for (int s = 0; s < HALF_LENGTH; s++) begin
        dx = step_of(-(y - c));
        dy = step_of(x - c);
        if (backward) begin
          x -= dx;
          y -= dy;
        end else begin
          x += dx;
          y += dy;
        end
        total += gray_at(x, y);
      end
      return total;
    endfunction

    // Add the store address of one in-image position to the list
    function void note_addr(longint x, longint y, ref int addrs[$]);
      longint ix, iy;
      if (x < 0 || y < 0) return;
      ix = x >>> FRAC_BITS;
      iy = y >>> FRAC_BITS;
      if (ix >= IMG_WIDTH || iy >= IMG_HEIGHT) return;
      addrs.insert(addrs.size(), int'(iy * IMG_WIDTH + ix));
    endfunction

    // List every store address that a compute at (px,py) samples
    function void trace_addrs(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                              ref int addrs[$]);
      longint c, x, y, dx, dy;
      c = longint'(FIELD_CENTER) << FRAC_BITS;
      addrs.delete();
      for (int h = 0; h < 2; h++) begin
        x = longint'(px) << FRAC_BITS;
        y = longint'(py) << FRAC_BITS;
        if (h == 0) note_addr(x, y, addrs);
        for (int s = 0; s < HALF_LENGTH; s++) begin
          dx = step_of(-(y - c));
          dy = step_of(x - c);
          if (h == 1) begin
            x -= dx;
            y -= dy;
          end else begin
            x += dx;
            y += dy;
          end
          note_addr(x, y, addrs);
        end
      end
    endfunction

    // Note one accepted item: write the store or queue the averaged pixel
    function void note_item(logic cmd, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                            logic [GRAY_W-1:0] g);
      longint     x0, y0;
      int         total;
      lic_pixel_t res;
      if (cmd == CMD_LOAD) begin
        loads++;
        if (px < IMG_WIDTH && py < IMG_HEIGHT) begin
          frame[py * IMG_WIDTH + px]   = g;
          written[py * IMG_WIDTH + px] = 1'b1;
        end
        return;
      end
      computes++;
      x0 = longint'(px) << FRAC_BITS;
      y0 = longint'(py) << FRAC_BITS;
      total = gray_at(x0, y0) + half_sum(x0, y0, 1'b0) + half_sum(x0, y0, 1'b1);
      res.x = px;
      res.y = py;
      res.gray = GRAY_W'(total / NPTS);
      awaited.insert(awaited.size(), res);
    endfunction

    // Check one accepted result against the oldest awaited pixel
    function void check_result(logic [TDATA_W-1:0] d);
      lic_pixel_t want;
      lic_pixel_t got;
      got.x    = d[PIX_W-1:0];
      got.y    = d[2*PIX_W-1:PIX_W];
      got.gray = d[2*PIX_W+GRAY_W-1:2*PIX_W];
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d gray=%0d", $time, got.x, got.y,
                 got.gray);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.x !== want.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.gray !== want.gray) begin
        $display("%0t: gray_out at (%0d,%0d) expected %0d actual %0d", $time, want.x,
                 want.y, want.gray, got.gray);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;   // pix_x, pix_y, gray_in, zero pad
  logic               in_tuser;   // cmd
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // out_x, out_y, gray_out, zero pad

  lic_scoreboard sb;
  bit            idle_on;
  bit            hold_req;
  int            cycles;

  line_integral_convolution dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("line_integral_convolution regression: fail");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Drive out_tready: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item, hold until accepted, then perhaps idle a burst
  task automatic send_item(logic cmd, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                           logic [GRAY_W-1:0] g);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(TDATA_W - 2*PIX_W - GRAY_W){1'b0}}, g, py, px};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, px, py, g);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Load any pixel the trace would sample that is still unwritten, then compute
  task automatic send_compute(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int addrs[$];
    sb.trace_addrs(px, py, addrs);
    foreach (addrs[k]) begin
      if (!sb.written[addrs[k]]) begin
        send_item(CMD_LOAD, PIX_W'(addrs[k] % IMG_WIDTH), PIX_W'(addrs[k] / IMG_WIDTH),
                  GRAY_W'($urandom));
      end
    end
    send_item(CMD_COMPUTE, px, py, GRAY_W'($urandom));
  endtask

  // Drop the input and wait until every awaited result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic cmd;
    sb = new();
    idle_on   = 1'b0;
    hold_req  = 1'b0;
    cycles    = 0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = CMD_LOAD;
    in_tdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill a block around the field centre, back to back
    for (int y = BLOCK_LO; y <= BLOCK_HI; y++)
      for (int x = BLOCK_LO; x <= BLOCK_HI; x++)
        send_item(CMD_LOAD, PIX_W'(x), PIX_W'(y), GRAY_W'($urandom));

    // Directed: extreme grays, corners, centre and edges
    idle_on = 1'b1;
    send_item(CMD_LOAD, 9'd0, 9'd0, 8'd255);
    send_item(CMD_LOAD, 9'd511, 9'd511, 8'd0);
    send_item(CMD_LOAD, 9'd256, 9'd256, 8'd255);
    send_compute(9'd0, 9'd0);
    send_compute(9'd511, 9'd511);
    send_compute(9'd0, 9'd511);
    send_compute(9'd511, 9'd0);
    send_compute(9'd256, 9'd256);
    send_compute(9'd255, 9'd256);
    send_compute(9'd256, 9'd0);
    send_compute(9'd0, 9'd256);
    send_compute(9'd511, 9'd256);
    send_compute(9'd256, 9'd511);
    send_compute(9'd251, 9'd261);

    // Sender pause until every result is back
    wait_drained();

    // Long receiver hold-off while computes keep arriving
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      send_compute(PIX_W'($urandom_range(ZONE_LO, ZONE_HI)),
                   PIX_W'($urandom_range(ZONE_LO, ZONE_HI)));

    // Random mix of loads and computes; last part without idling
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      cmd = ($urandom_range(0, 9) < 6) ? CMD_LOAD : CMD_COMPUTE;
      if (cmd == CMD_LOAD) begin
        send_item(CMD_LOAD, PIX_W'($urandom), PIX_W'($urandom), GRAY_W'($urandom));
      end else begin
        send_compute(PIX_W'($urandom_range(ZONE_LO, ZONE_HI)),
                     PIX_W'($urandom_range(ZONE_LO, ZONE_HI)));
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d loads (centre block, trace fill, random) and %0d computes,",
             sb.loads, sb.computes);
    $display("%0d results checked with random stalls on both sides", sb.checked);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("line_integral_convolution regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.awaited.size());
      $display("line_integral_convolution regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lic_pkg.sv
rtl/lic_ram.sv
rtl/line_integral_convolution.sv
dv/line_integral_convolution_tb.sv
